@@ rtl/dlcg_pkg.sv @@
package dlcg_pkg;

    // Field widths fixed by the segment and pixel formats
    localparam int COORD_W = 12;
    localparam int CH_W    = 8;
    localparam int COLOR_W = 3 * CH_W;

    // Defaults for the top-level parameters
    localparam int MAX_SPAN_DEF  = 63;
    localparam int FRAC_BITS_DEF = 16;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV_START,
        S_DIV_WAIT,
        S_EMIT
    } t_state;

    // Which quotient the shared divider is working on
    typedef enum logic [2:0] {
        DIV_X,
        DIV_Y,
        DIV_R,
        DIV_G,
        DIV_B
    } t_div_sel;

endpackage

@@ rtl/dlcg_div.sv @@
// Restoring divider, one quotient bit per cycle.
// Fraction mode: quot = (num << FRAC_BITS) / den, with num <= den.
// Channel mode:  quot = num[CH_W-1:0] / den.
module dlcg_div import dlcg_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic                 i_frac,
    input  logic [COORD_W-1:0]   i_num,
    input  logic [COORD_W-1:0]   i_den,
    output logic                 o_done,
    output logic [FRAC_BITS:0]   o_quot
);

    localparam int QW = FRAC_BITS + 1;
    localparam int NW = $clog2(QW + 1);

    logic                r_busy;
    logic                r_done;
    logic [NW-1:0]       r_left;
    logic [COORD_W-1:0]  r_rem;
    logic [QW-1:0]       r_sr;

    logic [COORD_W:0]    w_trial;
    logic [COORD_W:0]    w_diff;
    logic                w_ge;
    logic [COORD_W-1:0]  n_rem;
    logic [QW-1:0]       n_sr;

    // Shift in the next dividend bit and try a subtract
    always_comb begin
        w_trial = {r_rem, r_sr[QW-1]};
        w_diff  = w_trial - {1'b0, i_den};
        w_ge    = (w_trial >= {1'b0, i_den});
        n_rem   = w_ge ? w_diff[COORD_W-1:0] : w_trial[COORD_W-1:0];
        n_sr    = {r_sr[QW-2:0], w_ge};
    end

    // Control: busy flag, iteration count, done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_left <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_left <= i_frac ? NW'(QW) : NW'(CH_W);
            end else if (r_busy) begin
                r_left <= r_left - 1'b1;
                if (r_left == NW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: partial remainder and dividend/quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            if (i_frac) begin
                // leading quotient bits are zero since num <= den: skip them
                r_rem <= {1'b0, i_num[COORD_W-1:1]};
                r_sr  <= {i_num[0], {(QW-1){1'b0}}};
            end else begin
                r_rem <= '0;
                r_sr  <= {i_num[CH_W-1:0], {(QW-CH_W){1'b0}}};
            end
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_sr  <= n_sr;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_sr;

endmodule

@@ rtl/dda_line_color_gradient.sv @@
// DDA line rasterizer with per-channel color stepping.
//
// Input channel (i_valid / o_ready): one line segment per transaction, start and
// end points plus a start and end color. Output channel (o_valid / i_ready): one
// pixel per transaction, in drawing order, with o_last_pixel on the final pixel
// and o_span_clipped on every pixel of a segment longer than MAX_SPAN.
//
// A segment is taken only while the block is idle. Setup runs five divisions on
// one shared restoring divider: two for the x and y steps, three for the color
// steps. A zero-length segment skips setup, and its pixel follows acceptance in
// the next cycle. Pixels then leave at one per cycle while the receiver is ready,
// up to MAX_SPAN+1 of them.
//
// When the receiver stalls, the current pixel holds on the outputs and the walk
// pauses. Synchronous reset returns to idle with no pixel pending; nothing else
// needs clearing.
module dda_line_color_gradient import dlcg_pkg::*; #(
    parameter int MAX_SPAN  = MAX_SPAN_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic signed [COORD_W-1:0]  i_start_x,
    input  logic signed [COORD_W-1:0]  i_start_y,
    input  logic signed [COORD_W-1:0]  i_end_x,
    input  logic signed [COORD_W-1:0]  i_end_y,
    input  logic [COLOR_W-1:0]         i_start_color,
    input  logic [COLOR_W-1:0]         i_end_color,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic signed [COORD_W-1:0]  o_pixel_x,
    output logic signed [COORD_W-1:0]  o_pixel_y,
    output logic [COLOR_W-1:0]         o_pixel_color,
    output logic                       o_span_clipped,
    output logic                       o_last_pixel
);

    localparam int AW = COORD_W + 1 + FRAC_BITS;  // coordinate accumulator
    localparam int IW = FRAC_BITS + 2;            // signed coordinate step
    localparam int CW = (MAX_SPAN > 1) ? $clog2(MAX_SPAN + 1) : 1;

    t_state    r_state, n_state;
    t_div_sel  r_sel, n_sel;

    logic                       w_in_fire;
    logic                       w_out_fire;
    logic                       w_div_start;
    logic                       w_div_frac;
    logic [COORD_W-1:0]         w_div_num;
    logic                       w_div_done;
    logic [FRAC_BITS:0]         w_quot;

    // Segment setup terms
    logic signed [COORD_W:0]    w_dx, w_dy;
    logic [COORD_W-1:0]         w_ax, w_ay, w_step;
    logic                       w_clip;
    logic [CH_W:0]              w_cd   [3];
    logic [CH_W-1:0]            w_cmag [3];

    // Per-segment registers
    logic [COORD_W-1:0]         r_ax, r_ay, r_step;
    logic                       r_xneg, r_yneg;
    logic [CH_W-1:0]            r_cmag [3];
    logic                       r_cneg [3];
    logic                       r_clipped;
    logic [CW-1:0]              r_last_idx;
    logic [CW-1:0]              r_cnt;
    logic signed [AW-1:0]       r_xacc, r_yacc;
    logic signed [IW-1:0]       r_xinc, r_yinc;
    logic [CH_W-1:0]            r_ch   [3];
    logic [CH_W-1:0]            r_cinc [3];
    logic                       w_last;

    logic [IW-1:0]              w_qext;
    logic [CH_W-1:0]            w_q8;
    logic signed [AW-1:0]       w_xq, w_yq;

    assign w_in_fire  = i_valid && o_ready;
    assign w_out_fire = o_valid && i_ready;
    assign w_last     = (r_cnt == r_last_idx);

    // Deltas, magnitudes and span from the segment on the input
    always_comb begin
        w_dx   = {i_end_x[COORD_W-1], i_end_x} - {i_start_x[COORD_W-1], i_start_x};
        w_dy   = {i_end_y[COORD_W-1], i_end_y} - {i_start_y[COORD_W-1], i_start_y};
        w_ax   = w_dx[COORD_W] ? COORD_W'(-w_dx) : w_dx[COORD_W-1:0];
        w_ay   = w_dy[COORD_W] ? COORD_W'(-w_dy) : w_dy[COORD_W-1:0];
        w_step = (w_ax > w_ay) ? w_ax : w_ay;
        w_clip = (w_step > COORD_W'(MAX_SPAN));
        for (int k = 0; k < 3; k++) begin
            w_cd[k]   = {1'b0, i_end_color[(2-k)*CH_W +: CH_W]}
                      - {1'b0, i_start_color[(2-k)*CH_W +: CH_W]};
            w_cmag[k] = w_cd[k][CH_W] ? CH_W'(-w_cd[k]) : w_cd[k][CH_W-1:0];
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = (w_step == '0) ? S_EMIT : S_DIV_START;
                end
            end
            S_DIV_START: begin
                n_state = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (w_div_done) begin
                    n_state = (r_sel == DIV_B) ? S_EMIT : S_DIV_START;
                end
            end
            S_EMIT: begin
                if (i_ready && w_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        o_ready     = 1'b0;
        o_valid     = 1'b0;
        w_div_start = 1'b0;
        unique case (r_state)
            S_IDLE:      o_ready     = 1'b1;
            S_DIV_START: w_div_start = 1'b1;
            S_DIV_WAIT:  ;
            S_EMIT:      o_valid     = 1'b1;
            default:     ;
        endcase
    end

    // Divider operand select and next quotient slot
    always_comb begin
        w_div_frac = 1'b0;
        w_div_num  = '0;
        n_sel      = r_sel;
        unique case (r_sel)
            DIV_X: begin
                w_div_frac = 1'b1;
                w_div_num  = r_ax;
                n_sel      = DIV_Y;
            end
            DIV_Y: begin
                w_div_frac = 1'b1;
                w_div_num  = r_ay;
                n_sel      = DIV_R;
            end
            DIV_R: begin
                w_div_num = {{(COORD_W-CH_W){1'b0}}, r_cmag[0]};
                n_sel     = DIV_G;
            end
            DIV_G: begin
                w_div_num = {{(COORD_W-CH_W){1'b0}}, r_cmag[1]};
                n_sel     = DIV_B;
            end
            DIV_B: begin
                w_div_num = {{(COORD_W-CH_W){1'b0}}, r_cmag[2]};
                n_sel     = DIV_B;
            end
            default: n_sel = DIV_X;
        endcase
    end

    dlcg_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_frac  (w_div_frac),
        .i_num   (w_div_num),
        .i_den   (r_step),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    assign w_qext = {1'b0, w_quot};
    assign w_q8   = w_quot[CH_W-1:0];

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sel   <= DIV_X;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (w_in_fire) begin
                r_sel <= DIV_X;
                r_cnt <= '0;
            end else begin
                if (r_state == S_DIV_WAIT && w_div_done) begin
                    r_sel <= n_sel;
                end
                if (w_out_fire) begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    // Segment capture, step results and the pixel walk
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_ax       <= w_ax;
            r_ay       <= w_ay;
            r_step     <= w_step;
            r_xneg     <= w_dx[COORD_W];
            r_yneg     <= w_dy[COORD_W];
            r_clipped  <= w_clip;
            r_last_idx <= w_clip ? CW'(MAX_SPAN) : w_step[CW-1:0];
            r_xacc     <= {i_start_x[COORD_W-1], i_start_x, {FRAC_BITS{1'b0}}};
            r_yacc     <= {i_start_y[COORD_W-1], i_start_y, {FRAC_BITS{1'b0}}};
            r_xinc     <= '0;
            r_yinc     <= '0;
            for (int k = 0; k < 3; k++) begin
                r_cmag[k] <= w_cmag[k];
                r_cneg[k] <= w_cd[k][CH_W];
                r_ch[k]   <= i_start_color[(2-k)*CH_W +: CH_W];
                r_cinc[k] <= '0;
            end
        end else if (r_state == S_DIV_WAIT && w_div_done) begin
            // apply the sign to the magnitude quotient
            case (r_sel)
                DIV_X:   r_xinc    <= r_xneg ? IW'(-w_qext) : w_qext;
                DIV_Y:   r_yinc    <= r_yneg ? IW'(-w_qext) : w_qext;
                DIV_R:   r_cinc[0] <= r_cneg[0] ? CH_W'(~w_q8 + 1'b1) : w_q8;
                DIV_G:   r_cinc[1] <= r_cneg[1] ? CH_W'(~w_q8 + 1'b1) : w_q8;
                DIV_B:   r_cinc[2] <= r_cneg[2] ? CH_W'(~w_q8 + 1'b1) : w_q8;
                default: ;
            endcase
        end else if (w_out_fire) begin
            // advance to the next pixel
            r_xacc <= r_xacc + AW'(r_xinc);
            r_yacc <= r_yacc + AW'(r_yinc);
            for (int k = 0; k < 3; k++) begin
                r_ch[k] <= r_ch[k] + r_cinc[k];
            end
        end
    end

    // Truncate accumulators toward zero
    assign w_xq = r_xacc >>> FRAC_BITS;
    assign w_yq = r_yacc >>> FRAC_BITS;

    assign o_pixel_x = w_xq[COORD_W-1:0]
                     + COORD_W'(r_xacc[AW-1] && (r_xacc[FRAC_BITS-1:0] != '0));
    assign o_pixel_y = w_yq[COORD_W-1:0]
                     + COORD_W'(r_yacc[AW-1] && (r_yacc[FRAC_BITS-1:0] != '0));
    assign o_pixel_color  = {r_ch[0], r_ch[1], r_ch[2]};
    assign o_span_clipped = r_clipped;
    assign o_last_pixel   = w_last;

endmodule

@@ dv/dda_line_color_gradient_tb.sv @@
`timescale 1ns / 100ps

module dda_line_color_gradient_tb;
    import dlcg_pkg::*;

    localparam int SPAN_LIMIT      = MAX_SPAN_DEF;
    localparam int FRAC            = FRAC_BITS_DEF;
    localparam int RANDOM_SEGMENTS = 80;
    localparam int TAIL_CYCLES     = 2 * FRAC + SPAN_LIMIT + 60;
    localparam int HOLD_AT         = 1500;
    localparam int HOLD_LEN        = 400;
    localparam int MAX_REPORTS     = 10;
    localparam int COORD_MIN       = -2048;
    localparam int COORD_MAX       = 2047;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COLOR_W-1:0] color;
        logic               clipped;
        logic               last;
    } t_pixel;

    // Predict the pixels of each accepted segment and check them in drawing order
    class pixel_tracker;
        t_pixel expected_pixels[$];
        int     failures;
        int     pixels_checked;
        int     segments;
        int     clipped_segments;
        int     zero_segments;

        function void note_fail(string msg);
            failures++;
            if (failures <= MAX_REPORTS) begin
                $display("%s", msg);
            end
        endfunction

        function void add_segment(logic signed [COORD_W-1:0] sx,
                                  logic signed [COORD_W-1:0] sy,
                                  logic signed [COORD_W-1:0] ex,
                                  logic signed [COORD_W-1:0] ey,
                                  logic [COLOR_W-1:0] sc, logic [COLOR_W-1:0] ec);
            int         sxi, syi, exi, eyi;
            int         dx, dy, adx, ady, span, count, s_ch, e_ch, d;
            longint     scale, xacc, yacc, xinc, yinc;
            logic [7:0] ch [3];
            logic [7:0] ch_step [3];
            logic       clipped;
            t_pixel     p;
            sxi = sx;
            syi = sy;
            exi = ex;
            eyi = ey;
            dx = exi - sxi;
            dy = eyi - syi;
            adx = (dx < 0) ? -dx : dx;
            ady = (dy < 0) ? -dy : dy;
            span = (adx > ady) ? adx : ady;
            scale = longint'(1) <<< FRAC;
            xacc = longint'(sxi) * scale;
            yacc = longint'(syi) * scale;
            xinc = 0;
            yinc = 0;

            // Per-channel step, truncated toward zero, kept modulo 256
            for (int k = 0; k < 3; k++) begin
                s_ch = sc[16 - 8 * k +: 8];
                e_ch = ec[16 - 8 * k +: 8];
                d = (span > 0) ? (e_ch - s_ch) / span : 0;
                ch[k] = s_ch[7:0];
                ch_step[k] = d[7:0];
            end
            if (span > 0) begin
                xinc = (longint'(dx) * scale) / span;
                yinc = (longint'(dy) * scale) / span;
            end

            clipped = (span > SPAN_LIMIT);
            count = clipped ? SPAN_LIMIT + 1 : span + 1;
            segments++;
            if (clipped) clipped_segments++;
            if (span == 0) zero_segments++;

            // Walk the accumulators and queue one pixel per step
            for (int i = 0; i < count; i++) begin
                p.x = 12'(xacc / scale);
                p.y = 12'(yacc / scale);
                p.color = {ch[0], ch[1], ch[2]};
                p.clipped = clipped;
                p.last = (i == count - 1);
                expected_pixels.push_back(p);
                xacc += xinc;
                yacc += yinc;
                for (int k = 0; k < 3; k++) begin
                    ch[k] = ch[k] + ch_step[k];
                end
            end
        endfunction

        function void check_pixel(t_pixel got);
            t_pixel want;
            if (expected_pixels.size() == 0) begin
                note_fail($sformatf(
                    "unexpected pixel x=%0d y=%0d color=%06h clip=%0b last=%0b",
                    $signed(got.x), $signed(got.y), got.color,
                    got.clipped, got.last));
                return;
            end
            want = expected_pixels.pop_front();
            pixels_checked++;
            if (got.x !== want.x || got.y !== want.y || got.color !== want.color ||
                got.clipped !== want.clipped || got.last !== want.last) begin
                note_fail($sformatf({"pixel %0d: expected x=%0d y=%0d color=%06h ",
                                     "clip=%0b last=%0b, got x=%0d y=%0d color=%06h ",
                                     "clip=%0b last=%0b"},
                    pixels_checked, $signed(want.x), $signed(want.y), want.color,
                    want.clipped, want.last, $signed(got.x), $signed(got.y), got.color,
                    got.clipped, got.last));
            end
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction

        function void check_drained();
            if (expected_pixels.size() != 0) begin
                note_fail($sformatf("%0d expected pixels never arrived",
                                    expected_pixels.size()));
            end
        endfunction
    endclass

    logic                      i_clk;
    logic                      i_rst_n       = 1'b0;
    logic                      i_valid       = 1'b0;
    logic                      o_ready;
    logic signed [COORD_W-1:0] i_start_x     = '0;
    logic signed [COORD_W-1:0] i_start_y     = '0;
    logic signed [COORD_W-1:0] i_end_x       = '0;
    logic signed [COORD_W-1:0] i_end_y       = '0;
    logic [COLOR_W-1:0]        i_start_color = '0;
    logic [COLOR_W-1:0]        i_end_color   = '0;
    logic                      o_valid;
    logic                      i_ready       = 1'b0;
    logic signed [COORD_W-1:0] o_pixel_x;
    logic signed [COORD_W-1:0] o_pixel_y;
    logic [COLOR_W-1:0]        o_pixel_color;
    logic                      o_span_clipped;
    logic                      o_last_pixel;

    pixel_tracker tracker = new();
    int           directed_segments;
    logic         no_idle = 1'b0;

    dda_line_color_gradient #(
        .MAX_SPAN  (SPAN_LIMIT),
        .FRAC_BITS (FRAC)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_start_x      (i_start_x),
        .i_start_y      (i_start_y),
        .i_end_x        (i_end_x),
        .i_end_y        (i_end_y),
        .i_start_color  (i_start_color),
        .i_end_color    (i_end_color),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_pixel_x      (o_pixel_x),
        .o_pixel_y      (o_pixel_y),
        .o_pixel_color  (o_pixel_color),
        .o_span_clipped (o_span_clipped),
        .o_last_pixel   (o_last_pixel)
    );

    // Free-running clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Offer one segment, optionally after a random gap, and hold it until accepted
    task automatic send_segment(input int sx, input int sy, input int ex, input int ey,
                                input logic [COLOR_W-1:0] sc, input logic [COLOR_W-1:0] ec,
                                input bit allow_idle);
        int gap;
        if (allow_idle && $urandom_range(0, 99) < 23) begin
            gap = $urandom_range(1, 6);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_start_x     <= 12'(sx);
        i_start_y     <= 12'(sy);
        i_end_x       <= 12'(ex);
        i_end_y       <= 12'(ey);
        i_start_color <= sc;
        i_end_color   <= ec;
        do @(posedge i_clk); while (!o_ready);
        tracker.add_segment(12'(sx), 12'(sy), 12'(ex), 12'(ey), sc, ec);
    endtask

    // Drop valid and hold off until every predicted pixel has been seen
    task automatic wait_for_drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (tracker.pending() != 0);
    endtask

    function automatic int fit_end(int s, int d);
        int e;
        e = s + d;
        if (e > COORD_MAX || e < COORD_MIN) e = s - d;
        return e;
    endfunction

    // Mostly short and near-limit segments, some zero-length, some spanning the screen
    task automatic random_segment(input bit allow_idle);
        int sx, sy, ex, ey, dx, dy, mag, other, pick;
        pick = $urandom_range(0, 99);
        sx = int'($urandom_range(0, 4095)) + COORD_MIN;
        sy = int'($urandom_range(0, 4095)) + COORD_MIN;
        dx = 0;
        dy = 0;
        if (pick < 8) begin
            dx = 0;
            dy = 0;
        end else if (pick < 60) begin
            dx = int'($urandom_range(0, 80)) - 40;
            dy = int'($urandom_range(0, 80)) - 40;
        end else if (pick < 82) begin
            mag = $urandom_range(SPAN_LIMIT - 2, SPAN_LIMIT + 3);
            other = int'($urandom_range(0, 2 * mag)) - mag;
            if ($urandom_range(0, 1)) begin
                dx = $urandom_range(0, 1) ? mag : -mag;
                dy = other;
            end else begin
                dy = $urandom_range(0, 1) ? mag : -mag;
                dx = other;
            end
        end
        if (pick < 82) begin
            ex = fit_end(sx, dx);
            ey = fit_end(sy, dy);
        end else begin
            ex = int'($urandom_range(0, 4095)) + COORD_MIN;
            ey = int'($urandom_range(0, 4095)) + COORD_MIN;
        end
        send_segment(sx, sy, ex, ey, 24'($urandom), 24'($urandom), allow_idle);
    endtask

    // Receiver: check each pixel transaction, then choose ready for the next cycle
    initial begin
        int cycle;
        t_pixel got;
        cycle = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (o_valid && i_ready) begin
                got.x       = o_pixel_x;
                got.y       = o_pixel_y;
                got.color   = o_pixel_color;
                got.clipped = o_span_clipped;
                got.last    = o_last_pixel;
                tracker.check_pixel(got);
            end
            cycle++;
            if (cycle >= HOLD_AT && cycle < HOLD_AT + HOLD_LEN) begin
                i_ready <= 1'b0;
            end else if (no_idle) begin
                i_ready <= 1'b1;
            end else begin
                i_ready <= ($urandom_range(0, 99) >= 23);
            end
        end
    end

    // Sender: reset, directed segments, then random segments
    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Zero-length segments, including the coordinate extremes
        send_segment(0, 0, 0, 0, 24'h123456, 24'hABCDEF, 1'b1);
        send_segment(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, 24'hFFFFFF, 24'h000000, 1'b1);
        send_segment(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 24'h000000, 24'hFFFFFF, 1'b1);
        // Axis-aligned, diagonal and fractional walks
        send_segment(0, 0, 10, 0, 24'h000000, 24'hFFFFFF, 1'b1);
        send_segment(5, 5, 5, -7, 24'hFFFFFF, 24'h000000, 1'b1);
        send_segment(-3, -3, 4, 4, 24'h10FF80, 24'h800010, 1'b1);
        send_segment(0, 0, -3, -7, 24'h100000, 24'h000010, 1'b1);
        send_segment(1, -1, -6, 2, 24'h00FF00, 24'hFF00FF, 1'b1);
        // Span just at and just past the limit
        send_segment(0, 0, SPAN_LIMIT, 20, 24'h000000, 24'hFFFFFF, 1'b1);
        send_segment(0, 0, -20, -(SPAN_LIMIT + 1), 24'hFFFFFF, 24'h000000, 1'b1);
        send_segment(COORD_MAX, 0, COORD_MAX - SPAN_LIMIT, 5, 24'hFF0000, 24'h00FFFF, 1'b1);
        // Full-screen and half-screen spans, cut at the limit
        send_segment(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 24'h000000, 24'hFFFFFF, 1'b1);
        send_segment(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, 24'hFFFFFF, 24'h000000, 1'b1);
        send_segment(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, 24'h55AA55, 24'hAA55AA, 1'b1);
        send_segment(COORD_MIN, 0, COORD_MIN + 63, COORD_MIN, 24'h0F0F0F, 24'hF0F0F0, 1'b1);
        // Short steps and negative color increments that wrap
        send_segment(100, 200, 101, 201, 24'hFF00FF, 24'h00FF00, 1'b1);
        send_segment(0, 0, 1, 0, 24'hFFFFFF, 24'hFFFFFF, 1'b1);
        send_segment(-1, 0, -1, -63, 24'h808080, 24'h7F7F7F, 1'b1);
        send_segment(7, -9, -30, 33, 24'hABCDEF, 24'h123456, 1'b1);
        send_segment(0, 0, 3, 0, 24'h101010, 24'h000000, 1'b1);
        directed_segments = tracker.segments;

        // Pause until the pipeline is empty before the random part
        wait_for_drain();
        for (int n = 0; n < RANDOM_SEGMENTS; n++) begin
            if (n == RANDOM_SEGMENTS / 2) wait_for_drain();
            // Run both sides without idling over a long stretch
            no_idle = (n >= 60 && n < 80);
            random_segment(!no_idle);
        end
        no_idle = 1'b0;
        i_valid <= 1'b0;

        // Drain, then allow a latency tail for stray pixels
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        tracker.check_drained();

        $display("ran %0d segments (%0d directed): %0d zero-length, %0d cut at the span limit",
                 tracker.segments, directed_segments, tracker.zero_segments,
                 tracker.clipped_segments);
        $display("checked %0d pixels with random stalls and a %0d-cycle receiver hold-off",
                 tracker.pixels_checked, HOLD_LEN);
        if (tracker.failures == 0) begin
            $display("dda_line_color_gradient_tb: PASS");
        end else begin
            $display("%0d failures", tracker.failures);
            $display("dda_line_color_gradient_tb: FAIL");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #1_000_000;
        $display("timeout with %0d pixels outstanding", tracker.pending());
        $display("dda_line_color_gradient_tb: FAIL");
        $finish;
    end

endmodule
